### src/lft_pkg.sv
// Shared types, widths and constants of the lane fit tracker.
// Used by the lane core, the merge stage, the top level and the checker.
package lft_pkg;

  // Field and datapath widths.
  localparam int unsigned CoefW     = 32;
  localparam int unsigned CfgW      = 10;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned AlphaW    = 9;
  localparam int unsigned MaxLostW  = 6;
  localparam int unsigned LostW     = 7;
  localparam int unsigned FracW     = 30;
  localparam int unsigned PxW       = 24;
  localparam int unsigned SumPxW    = 25;
  localparam int unsigned AccW      = 54;
  localparam int unsigned ProdW     = 54;
  localparam int unsigned MulAW     = 43;
  localparam int unsigned MulBW     = 11;
  localparam int unsigned SlopeW    = 44;
  localparam int unsigned OutPxW    = 12;
  localparam int unsigned HeadW     = 15;
  localparam int unsigned InDataW   = 200;
  localparam int unsigned OutDataW  = 56;

  // Heading conversion: 1800/pi in Q16, and the saturation bound.
  localparam int unsigned HeadKW = 26;
  localparam logic [HeadKW-1:0] HEAD_K   = 26'd37549362;
  localparam logic [HeadW-1:0]  HEAD_MAX = 15'd9000;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_ALPHA          = 3'd0,
    CFG_MAX_LOST       = 3'd1,
    CFG_MIN_SEPARATION = 3'd2,
    CFG_JUMP_TOLERANCE = 3'd3,
    CFG_BASE_ROW       = 3'd4,
    CFG_IMAGE_CENTER   = 3'd5
  } cfg_idx_e;

  // Configuration reset values.
  localparam logic [AlphaW-1:0]   ALPHA_RST    = 9'd77;
  localparam logic [MaxLostW-1:0] MAX_LOST_RST = 6'd12;
  localparam logic [CfgW-1:0]     MIN_SEP_RST  = 10'd150;
  localparam logic [CfgW-1:0]     JUMP_TOL_RST = 10'd60;
  localparam logic [CfgW-1:0]     BASE_ROW_RST = 10'd479;
  localparam logic [CfgW-1:0]     CENTER_RST   = 10'd320;

  // Micro-operation sequence, issued to both lanes and the merge stage each cycle.
  localparam int unsigned OpW = 5;
  typedef enum logic [OpW-1:0] {
    LOP_NOP     = 5'd0,
    LOP_EVN_AY  = 5'd1,
    LOP_EVN_AYY = 5'd2,
    LOP_EVN_BY  = 5'd3,
    LOP_EVO_AY  = 5'd4,
    LOP_EVO_AYY = 5'd5,
    LOP_EVO_BY  = 5'd6,
    LOP_EVO_END = 5'd7,
    LOP_EVO_X   = 5'd8,
    LOP_BL_A    = 5'd9,
    LOP_BL_B    = 5'd10,
    LOP_BL_C    = 5'd11,
    LOP_UPDATE  = 5'd12,
    LOP_EVT_AY  = 5'd13,
    LOP_EVT_AYY = 5'd14,
    LOP_EVT_BY  = 5'd15,
    LOP_EVT_END = 5'd16,
    LOP_EVT_X   = 5'd17,
    LOP_MRG_SUM = 5'd18,
    LOP_MRG_MUL = 5'd19,
    LOP_MRG_OUT = 5'd20
  } lane_op_e;

  // Per-lane decision from the merge stage.
  typedef struct packed {
    logic take;
    logic lose;
  } lane_dec_t;

  // What a lane reports to the merge stage.
  typedef struct packed {
    logic                     found;
    logic                     valid;
    logic                     plausible;
    logic signed [PxW-1:0]    x_new;
    logic signed [PxW-1:0]    x_trk;
    logic signed [SlopeW-1:0] slope;
  } lane_stat_t;

  // One result item.
  typedef struct packed {
    logic                     publish;
    logic                     left_ok;
    logic                     right_ok;
    logic signed [OutPxW-1:0] left_base_x;
    logic signed [OutPxW-1:0] right_base_x;
    logic signed [OutPxW-1:0] offset_px;
    logic signed [HeadW-1:0]  heading_tenths;
  } result_t;

endpackage

### src/lft_lane.sv
// One lane of the tracker: smoothed fit state of one line and a shared multiplier
// that evaluates fits at the base row and blends new fits. Depends on lft_pkg.
module lft_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lft_pkg::lane_op_e             op_i,
  input  logic                          load_i,
  input  logic                          found_i,
  input  logic [lft_pkg::CoefW-1:0]     a_i,
  input  logic [lft_pkg::CoefW-1:0]     b_i,
  input  logic [lft_pkg::CoefW-1:0]     c_i,
  input  logic [lft_pkg::CfgW-1:0]      y_i,
  input  logic [lft_pkg::AlphaW-1:0]    alpha_i,
  input  logic [lft_pkg::CfgW-1:0]      tol_i,
  input  logic [lft_pkg::MaxLostW-1:0]  max_lost_i,
  input  lft_pkg::lane_dec_t            dec_i,
  output lft_pkg::lane_stat_t           stat_o
);
  import lft_pkg::*;

  localparam logic [AccW-1:0] TruncBias = {{(AccW-FracW){1'b0}}, {FracW{1'b1}}};
  localparam logic [AlphaW-1:0] AlphaOne = 9'd256;

  // Truncate a Q30 position toward zero to whole pixels.
  function automatic logic signed [PxW-1:0] px_trunc(input logic signed [AccW-1:0] v);
    logic [AccW-1:0] biased;
    biased = v + (v[AccW-1] ? TruncBias : '0);
    return biased[AccW-1:FracW];
  endfunction

  // Smoothed coefficient: floor((al*(new-old) + 256*old + 128) / 256).
  function automatic logic signed [CoefW-1:0] blend_fn(input logic [ProdW-1:0] p,
                                                       input logic signed [CoefW-1:0] old);
    logic [ProdW-1:0] sum;
    sum = p + {{(ProdW-CoefW-8){old[CoefW-1]}}, old, 8'b0} + ProdW'(128);
    return sum[CoefW+7:8];
  endfunction

  function automatic logic signed [MulAW-1:0] sx(input logic signed [CoefW:0] v);
    return {{(MulAW-CoefW-1){v[CoefW]}}, v};
  endfunction

  function automatic logic [AccW-1:0] c_term(input logic signed [CoefW-1:0] v);
    return {{(AccW-CoefW-10){v[CoefW-1]}}, v, 10'b0};
  endfunction

  // Fit state and working registers.
  logic                     found_q, found_d;
  logic                     valid_q, valid_d;
  logic [LostW-1:0]         lost_q, lost_d, lost_inc;
  logic signed [CoefW-1:0]  new_a_q, new_b_q, new_c_q, new_a_d, new_b_d, new_c_d;
  logic signed [CoefW-1:0]  trk_a_q, trk_b_q, trk_c_q, trk_a_d, trk_b_d, trk_c_d;
  logic signed [CoefW-1:0]  bla_q, blb_q, bla_d, blb_d;
  logic [ProdW-1:0]         prod_q;
  logic [AccW-1:0]          acc_q, acc_d;
  logic signed [PxW-1:0]    xn_q, xo_q, xt_q, xn_d, xo_d, xt_d;
  logic signed [SlopeW-1:0] slope_q, slope_d;

  logic [AlphaW-1:0]        al;
  logic signed [MulBW-1:0]  y_s, al_s, mul_b;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [ProdW-1:0]  mul_p;
  logic signed [CoefW:0]    da, db, dc;
  logic signed [SumPxW-1:0] dx, adx;
  logic                     plausible;

  // Operand selection for the shared multiplier.
  assign al   = (alpha_i > AlphaOne) ? AlphaOne : alpha_i;
  assign y_s  = $signed({1'b0, y_i});
  assign al_s = $signed({{(MulBW-AlphaW){1'b0}}, al});
  assign da   = {new_a_q[CoefW-1], new_a_q} - {trk_a_q[CoefW-1], trk_a_q};
  assign db   = {new_b_q[CoefW-1], new_b_q} - {trk_b_q[CoefW-1], trk_b_q};
  assign dc   = {new_c_q[CoefW-1], new_c_q} - {trk_c_q[CoefW-1], trk_c_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      LOP_EVN_AY: begin
        mul_a = sx({new_a_q[CoefW-1], new_a_q});
        mul_b = y_s;
      end
      LOP_EVN_AYY, LOP_EVO_AYY, LOP_EVT_AYY: begin
        mul_a = prod_q[MulAW-1:0];
        mul_b = y_s;
      end
      LOP_EVN_BY: begin
        mul_a = sx({new_b_q[CoefW-1], new_b_q});
        mul_b = y_s;
      end
      LOP_EVO_AY, LOP_EVT_AY: begin
        mul_a = sx({trk_a_q[CoefW-1], trk_a_q});
        mul_b = y_s;
      end
      LOP_EVO_BY, LOP_EVT_BY: begin
        mul_a = sx({trk_b_q[CoefW-1], trk_b_q});
        mul_b = y_s;
      end
      LOP_BL_A: begin
        mul_a = sx(da);
        mul_b = al_s;
      end
      LOP_BL_B: begin
        mul_a = sx(db);
        mul_b = al_s;
      end
      LOP_BL_C: begin
        mul_a = sx(dc);
        mul_b = al_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Accumulation of the base-row position and capture of the derived values.
  always_comb begin
    acc_d   = acc_q;
    xn_d    = xn_q;
    xo_d    = xo_q;
    xt_d    = xt_q;
    slope_d = slope_q;
    bla_d   = bla_q;
    blb_d   = blb_q;
    case (op_i)
      LOP_EVN_BY:                          acc_d = prod_q + c_term(new_c_q);
      LOP_EVO_BY, LOP_EVT_BY:              acc_d = prod_q + c_term(trk_c_q);
      LOP_EVO_AY, LOP_EVO_END, LOP_EVT_END: acc_d = acc_q + {prod_q[ProdW-7:0], 6'b0};
      LOP_EVO_AYY:                         xn_d = px_trunc(acc_q);
      LOP_EVO_X:                           xo_d = px_trunc(acc_q);
      LOP_EVT_X:                           xt_d = px_trunc(acc_q);
      LOP_EVT_AYY: begin
        slope_d = {prod_q[SlopeW-2:0], 1'b0}
                + {{(SlopeW-CoefW-6){trk_b_q[CoefW-1]}}, trk_b_q, 6'b0};
      end
      LOP_BL_B:                            bla_d = blend_fn(prod_q, trk_a_q);
      LOP_BL_C:                            blb_d = blend_fn(prod_q, trk_b_q);
      default:                             acc_d = acc_q;
    endcase
  end

  // Jump test of a lone new fit against the current track.
  assign dx        = {xn_q[PxW-1], xn_q} - {xo_q[PxW-1], xo_q};
  assign adx       = dx[SumPxW-1] ? -dx : dx;
  assign plausible = !valid_q || (adx < $signed({{(SumPxW-CfgW){1'b0}}, tol_i}));

  // Capture of the new fit and the track update.
  assign lost_inc = lost_q + LostW'(1);

  always_comb begin
    found_d = found_q;
    new_a_d = new_a_q;
    new_b_d = new_b_q;
    new_c_d = new_c_q;
    trk_a_d = trk_a_q;
    trk_b_d = trk_b_q;
    trk_c_d = trk_c_q;
    valid_d = valid_q;
    lost_d  = lost_q;
    if (load_i) begin
      found_d = found_i;
      new_a_d = $signed(a_i);
      new_b_d = $signed(b_i);
      new_c_d = $signed(c_i);
    end
    if (op_i == LOP_UPDATE) begin
      if (dec_i.take) begin
        if (valid_q) begin
          trk_a_d = bla_q;
          trk_b_d = blb_q;
          trk_c_d = blend_fn(prod_q, trk_c_q);
        end else begin
          trk_a_d = new_a_q;
          trk_b_d = new_b_q;
          trk_c_d = new_c_q;
        end
        valid_d = 1'b1;
        lost_d  = '0;
      end else if (dec_i.lose && valid_q) begin
        lost_d  = lost_inc;
        valid_d = (lost_inc <= {1'b0, max_lost_i});
      end
    end
  end

  // Track state, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      valid_q <= 1'b0;
      lost_q  <= '0;
      trk_a_q <= '0;
      trk_b_q <= '0;
      trk_c_q <= '0;
    end else begin
      found_q <= found_d;
      valid_q <= valid_d;
      lost_q  <= lost_d;
      trk_a_q <= trk_a_d;
      trk_b_q <= trk_b_d;
      trk_c_q <= trk_c_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    new_a_q <= new_a_d;
    new_b_q <= new_b_d;
    new_c_q <= new_c_d;
    prod_q  <= mul_p;
    acc_q   <= acc_d;
    xn_q    <= xn_d;
    xo_q    <= xo_d;
    xt_q    <= xt_d;
    slope_q <= slope_d;
    bla_q   <= bla_d;
    blb_q   <= blb_d;
  end

  assign stat_o.found     = found_q;
  assign stat_o.valid     = valid_q;
  assign stat_o.plausible = plausible;
  assign stat_o.x_new     = xn_q;
  assign stat_o.x_trk     = xt_q;
  assign stat_o.slope     = slope_q;

endmodule

### src/lft_merge.sv
// Merge stage: decides per line whether to take the new fit or count a lost frame,
// and forms base positions, center offset and heading. Depends on lft_pkg.
module lft_merge (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lft_pkg::lane_op_e        op_i,
  input  logic                     overexposed_i,
  input  lft_pkg::lane_stat_t      stat_l_i,
  input  lft_pkg::lane_stat_t      stat_r_i,
  input  logic [lft_pkg::CfgW-1:0] min_sep_i,
  input  logic [lft_pkg::CfgW-1:0] center_i,
  output lft_pkg::lane_dec_t       dec_l_o,
  output lft_pkg::lane_dec_t       dec_r_o,
  output lft_pkg::result_t         res_o
);
  import lft_pkg::*;

  localparam int unsigned OffW      = 26;
  localparam int unsigned SumSlopeW = SlopeW + 1;
  localparam int unsigned HeadMagW  = 37;
  localparam int unsigned HeadProdW = HeadMagW + HeadKW;
  localparam int unsigned HeadRndW  = HeadProdW - 47;
  localparam logic signed [OffW-1:0] PxMax = 26'sd2047;
  localparam logic signed [OffW-1:0] PxMin = -26'sd2048;
  localparam logic [SumSlopeW-1:0] HeadClamp =
    {{(SumSlopeW-HeadMagW){1'b0}}, 1'b1, {(HeadMagW-1){1'b0}}};
  localparam logic [HeadProdW-1:0] HeadRound =
    {{(HeadProdW-47){1'b0}}, 1'b1, {46{1'b0}}};

  // Saturate a pixel value to the output range.
  function automatic logic signed [OutPxW-1:0] sat_px(input logic signed [OffW-1:0] v);
    if (v > PxMax) begin
      return PxMax[OutPxW-1:0];
    end else if (v < PxMin) begin
      return PxMin[OutPxW-1:0];
    end
    return v[OutPxW-1:0];
  endfunction

  lane_dec_t                   dec_l_q, dec_r_q, dec_l_d, dec_r_d;
  logic signed [OutPxW-1:0]    lx_q, rx_q, off_q, lx_d, rx_d, off_d;
  logic signed [SumPxW-1:0]    sum_q, sum_d, half;
  logic                        neg_q, neg_d;
  logic [HeadMagW-1:0]         mag_q, mag_d;
  logic [HeadProdW-1:0]        hprod_q, hprod_d, hrnd;
  logic signed [SumPxW-1:0]    sep;
  logic                        sep_bad;
  logic signed [SumSlopeW-1:0] s_sum;
  logic [SumSlopeW-1:0]        s_abs;
  logic [HeadRndW-1:0]         hmag;
  logic [HeadW-1:0]            hsat;
  logic signed [OffW-1:0]      off_full;
  logic                        publish;

  // Take or lose decision for both lines.
  assign sep     = {stat_r_i.x_new[PxW-1], stat_r_i.x_new}
                 - {stat_l_i.x_new[PxW-1], stat_l_i.x_new};
  assign sep_bad = sep < $signed({{(SumPxW-CfgW){1'b0}}, min_sep_i});

  always_comb begin
    dec_l_d = dec_l_q;
    dec_r_d = dec_r_q;
    if (op_i == LOP_BL_A) begin
      if (overexposed_i) begin
        dec_l_d = '{take: 1'b0, lose: 1'b1};
        dec_r_d = '{take: 1'b0, lose: 1'b1};
      end else if (stat_l_i.found && stat_r_i.found) begin
        dec_l_d = '{take: !sep_bad, lose: sep_bad};
        dec_r_d = '{take: !sep_bad, lose: sep_bad};
      end else begin
        dec_l_d.take = stat_l_i.found && stat_l_i.plausible;
        dec_l_d.lose = !dec_l_d.take;
        dec_r_d.take = stat_r_i.found && stat_r_i.plausible;
        dec_r_d.lose = !dec_r_d.take;
      end
    end
  end

  // Output stages: sums and slope clamp, then heading product and offset.
  // The half sum truncates toward zero: a negative sum is moved up by one first.
  assign s_sum    = {stat_l_i.slope[SlopeW-1], stat_l_i.slope}
                  + {stat_r_i.slope[SlopeW-1], stat_r_i.slope};
  assign s_abs    = s_sum[SumSlopeW-1] ? -s_sum : s_sum;
  assign half     = $signed(sum_q + {{(SumPxW-1){1'b0}}, sum_q[SumPxW-1]}) >>> 1;
  assign off_full = {half[SumPxW-1], half} - $signed({{(OffW-CfgW){1'b0}}, center_i});

  always_comb begin
    lx_d    = lx_q;
    rx_d    = rx_q;
    sum_d   = sum_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    hprod_d = hprod_q;
    off_d   = off_q;
    case (op_i)
      LOP_MRG_SUM: begin
        lx_d  = sat_px({{(OffW-PxW){stat_l_i.x_trk[PxW-1]}}, stat_l_i.x_trk});
        rx_d  = sat_px({{(OffW-PxW){stat_r_i.x_trk[PxW-1]}}, stat_r_i.x_trk});
        sum_d = {stat_l_i.x_trk[PxW-1], stat_l_i.x_trk}
              + {stat_r_i.x_trk[PxW-1], stat_r_i.x_trk};
        neg_d = s_sum[SumSlopeW-1];
        mag_d = (s_abs > HeadClamp) ? HeadClamp[HeadMagW-1:0] : s_abs[HeadMagW-1:0];
      end
      LOP_MRG_MUL: begin
        hprod_d = mag_q * HEAD_K;
        off_d   = sat_px(off_full);
      end
      default: begin
        hprod_d = hprod_q;
      end
    endcase
  end

  // Heading rounding and saturation.
  assign hrnd    = hprod_q + HeadRound;
  assign hmag    = hrnd[HeadProdW-1:47];
  assign hsat    = (hmag > HeadRndW'(HEAD_MAX)) ? HEAD_MAX : hmag[HeadW-1:0];
  assign publish = stat_l_i.valid && stat_r_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_l_q <= '0;
      dec_r_q <= '0;
    end else begin
      dec_l_q <= dec_l_d;
      dec_r_q <= dec_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q    <= lx_d;
    rx_q    <= rx_d;
    sum_q   <= sum_d;
    neg_q   <= neg_d;
    mag_q   <= mag_d;
    hprod_q <= hprod_d;
    off_q   <= off_d;
  end

  assign dec_l_o = dec_l_q;
  assign dec_r_o = dec_r_q;

  assign res_o.publish        = publish;
  assign res_o.left_ok        = stat_l_i.valid;
  assign res_o.right_ok       = stat_r_i.valid;
  assign res_o.left_base_x    = publish ? lx_q : '0;
  assign res_o.right_base_x   = publish ? rx_q : '0;
  assign res_o.offset_px      = publish ? off_q : '0;
  assign res_o.heading_tenths = !publish ? '0 : (neg_q ? -hsat : hsat);

endmodule

### src/lane_fit_tracker_unit.sv
// Top level of the lane fit tracker: stream ports, configuration registers, the
// operation sequencer, two line lanes and the merge stage. Depends on lft_pkg.
//
// One input item per frame carries the overexposure flag and the new left and right
// fits; one result item comes back for each. The block works on one item at a time:
// an item is accepted only while the sequencer is idle, and the input opens again in
// the cycle after its result enters the output register, so the next item waits for
// the whole sequence. The sequence is set by the single 43x11 multiplier in each lane,
// which runs twelve products in sequence (new and old base positions, three blends,
// the updated track), followed by three merge steps for offset and heading. The
// output register lets the next item in while a result still waits; a result that
// finds the register still full holds the sequencer until it drains. Configuration
// writes take effect at once and belong in the gaps between items.
module lane_fit_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // From bit 0: overexposed, left_found, left_a, left_b, left_c, right_found,
  // right_a, right_b, right_c, zero fill.
  input  logic [lft_pkg::InDataW-1:0]      s_axis_tdata,
  // Result items.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // From bit 0: publish, left_ok, right_ok, left_base_x, right_base_x, offset_px,
  // heading_tenths, zero fill.
  output logic [lft_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration writes.
  input  logic                             cfg_we_i,
  input  logic [lft_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [lft_pkg::CfgW-1:0]         cfg_wdata_i
);
  import lft_pkg::*;

  localparam int unsigned ResW = OutDataW - 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e               state_q;
  lane_op_e             op_q;
  logic                 over_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;

  logic [AlphaW-1:0]    alpha_q;
  logic [MaxLostW-1:0]  max_lost_q;
  logic [CfgW-1:0]      min_sep_q, tol_q, base_row_q, center_q;

  logic                 accept;
  logic                 out_free;
  logic                 res_load;
  lane_stat_t           stat_l, stat_r;
  lane_dec_t            dec_l, dec_r;
  result_t              res;
  logic [ResW-1:0]      res_bits;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign res_load      = (state_q == ST_RUN) && (op_q == LOP_MRG_OUT) && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q    <= ALPHA_RST;
      max_lost_q <= MAX_LOST_RST;
      min_sep_q  <= MIN_SEP_RST;
      tol_q      <= JUMP_TOL_RST;
      base_row_q <= BASE_ROW_RST;
      center_q   <= CENTER_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ALPHA:          alpha_q    <= cfg_wdata_i[AlphaW-1:0];
        CFG_MAX_LOST:       max_lost_q <= cfg_wdata_i[MaxLostW-1:0];
        CFG_MIN_SEPARATION: min_sep_q  <= cfg_wdata_i;
        CFG_JUMP_TOLERANCE: tol_q      <= cfg_wdata_i;
        CFG_BASE_ROW:       base_row_q <= cfg_wdata_i;
        CFG_IMAGE_CENTER:   center_q   <= cfg_wdata_i;
        default:            alpha_q    <= alpha_q;
      endcase
    end
  end

  // Result packing, first field in the lowest bits.
  assign res_bits = {res.heading_tenths, res.offset_px, res.right_base_x,
                     res.left_base_x, res.right_ok, res.left_ok, res.publish};

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= LOP_NOP;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {{(OutDataW-ResW){1'b0}}, res_bits};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
            op_q    <= LOP_EVN_AY;
            over_q  <= s_axis_tdata[0];
          end
        end
        ST_RUN: begin
          if (op_q == LOP_MRG_OUT) begin
            if (out_free) begin
              state_q <= ST_IDLE;
              op_q    <= LOP_NOP;
            end
          end else begin
            op_q <= lane_op_e'(OpW'(op_q) + OpW'(1));
          end
        end
        default: begin
          state_q <= ST_IDLE;
          op_q    <= LOP_NOP;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Left and right lanes.
  lft_lane u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_q),
    .load_i     (accept),
    .found_i    (s_axis_tdata[1]),
    .a_i        (s_axis_tdata[33:2]),
    .b_i        (s_axis_tdata[65:34]),
    .c_i        (s_axis_tdata[97:66]),
    .y_i        (base_row_q),
    .alpha_i    (alpha_q),
    .tol_i      (tol_q),
    .max_lost_i (max_lost_q),
    .dec_i      (dec_l),
    .stat_o     (stat_l)
  );

  lft_lane u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op_q),
    .load_i     (accept),
    .found_i    (s_axis_tdata[98]),
    .a_i        (s_axis_tdata[130:99]),
    .b_i        (s_axis_tdata[162:131]),
    .c_i        (s_axis_tdata[194:163]),
    .y_i        (base_row_q),
    .alpha_i    (alpha_q),
    .tol_i      (tol_q),
    .max_lost_i (max_lost_q),
    .dec_i      (dec_r),
    .stat_o     (stat_r)
  );

  // Decisions and output values.
  lft_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_q),
    .overexposed_i (over_q),
    .stat_l_i      (stat_l),
    .stat_r_i      (stat_r),
    .min_sep_i     (min_sep_q),
    .center_i      (center_q),
    .dec_l_o       (dec_l),
    .dec_r_o       (dec_r),
    .res_o         (res)
  );

endmodule

### src/lft_checker.sv
// Port-level checks of the lane fit tracker, attached to the top level by bind.
// Depends on lft_pkg and lane_fit_tracker_unit.
module lft_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lft_pkg::OutDataW-1:0]  m_axis_tdata
);
  import lft_pkg::*;

  logic signed [HeadW-1:0] head;

  assign head = m_axis_tdata[53:39];

  // One item at a time: the input side closes right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // A published result has both lines valid.
  a_publish_needs_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1] && m_axis_tdata[2])
    else $error("publish without both lines valid");

  // An unpublished result carries zero positions, offset and heading.
  a_quiet_when_unpublished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[53:3] == '0)
    else $error("unpublished result carries nonzero values");

  // The heading stays within its saturation bound.
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (head <= $signed(HEAD_MAX)) && (head >= -$signed(HEAD_MAX)))
    else $error("heading outside its saturation bound");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

endmodule

bind lane_fit_tracker_unit lft_checker u_lft_checker (.*);

### tb/lane_fit_tracker_tb_pkg.sv
// Frame types, item packing and the result scoreboard for the lane fit tracker bench.
// Depends on lft_pkg for widths, register indexes and the result layout.
package lane_fit_tracker_tb_pkg;
  import lft_pkg::*;

  // One quadratic fit x = A*y^2 + B*y + C (Q2.30, Q8.24, Q12.20).
  typedef struct packed {
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] c;
  } quad_fit_t;

  // One input item: a camera frame.
  typedef struct {
    logic      over;
    logic      left_found;
    quad_fit_t left;
    logic      right_found;
    quad_fit_t right;
  } lane_frame_t;

  // Tracked state of one line.
  typedef struct {
    quad_fit_t        fit;
    logic             valid;
    logic [LostW-1:0] lost;
  } line_track_t;

  localparam longint HeadClamp = longint'(1) << 36;
  localparam int unsigned ReportLimit = 10;

  // Lay a frame out on the input bus, overexposed flag in bit 0.
  function automatic logic [InDataW-1:0] pack_frame(lane_frame_t f);
    logic [InDataW-1:0] d;
    d = '0;
    d[0]       = f.over;
    d[1]       = f.left_found;
    d[33:2]    = f.left.a;
    d[65:34]   = f.left.b;
    d[97:66]   = f.left.c;
    d[98]      = f.right_found;
    d[130:99]  = f.right.a;
    d[162:131] = f.right.b;
    d[194:163] = f.right.c;
    return d;
  endfunction

  // Predicts the result of every accepted frame and checks the results in order.
  class lane_fit_scoreboard;
    logic [AlphaW-1:0]   alpha;
    logic [MaxLostW-1:0] max_lost;
    logic [CfgW-1:0]     min_sep;
    logic [CfgW-1:0]     jump_tol;
    logic [CfgW-1:0]     base_row;
    logic [CfgW-1:0]     center;
    line_track_t         left_track;
    line_track_t         right_track;
    result_t             expected_results[$];
    int unsigned         failures;

    function new();
      alpha       = ALPHA_RST;
      max_lost    = MAX_LOST_RST;
      min_sep     = MIN_SEP_RST;
      jump_tol    = JUMP_TOL_RST;
      base_row    = BASE_ROW_RST;
      center      = CENTER_RST;
      left_track  = '{'0, 1'b0, '0};
      right_track = '{'0, 1'b0, '0};
      failures    = 0;
    endfunction

    // Mirror a register write, masked to the register width.
    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CFG_ALPHA:          alpha    = value[AlphaW-1:0];
        CFG_MAX_LOST:       max_lost = value[MaxLostW-1:0];
        CFG_MIN_SEPARATION: min_sep  = value;
        CFG_JUMP_TOLERANCE: jump_tol = value;
        CFG_BASE_ROW:       base_row = value;
        CFG_IMAGE_CENTER:   center   = value;
        default: ;
      endcase
    endfunction

    // Pixel x at the base row, truncated toward zero from Q30.
    function longint x_at_base(quad_fit_t f);
      longint y;
      longint q;
      y = longint'(base_row);
      q = longint'(f.a) * y * y + longint'(f.b) * 64 * y + longint'(f.c) * 1024;
      if (q < 0) return -((-q) >>> 30);
      return q >>> 30;
    endfunction

    // Slope dx/dy at the base row in Q30.
    function longint slope_at_base(quad_fit_t f);
      return 2 * longint'(f.a) * longint'(base_row) + longint'(f.b) * 64;
    endfunction

    // Exponential smoothing of one coefficient, rounded, weight capped at 256.
    function logic signed [CoefW-1:0] smooth_coef(logic signed [CoefW-1:0] old_v,
                                                  logic signed [CoefW-1:0] new_v);
      longint w;
      longint acc;
      w   = (alpha > 9'd256) ? 256 : longint'(alpha);
      acc = w * longint'(new_v) + (256 - w) * longint'(old_v) + 128;
      acc = acc >>> 8;
      return acc[CoefW-1:0];
    endfunction

    function line_track_t take_fit(line_track_t t, quad_fit_t f);
      if (!t.valid) begin
        t.fit = f;
      end else begin
        t.fit.a = smooth_coef(t.fit.a, f.a);
        t.fit.b = smooth_coef(t.fit.b, f.b);
        t.fit.c = smooth_coef(t.fit.c, f.c);
      end
      t.valid = 1'b1;
      t.lost  = '0;
      return t;
    endfunction

    // A lost frame only counts on a valid line; past the limit the line drops.
    function line_track_t lose_frame(line_track_t t);
      if (!t.valid) return t;
      t.lost = t.lost + 1'b1;
      if (t.lost > {1'b0, max_lost}) t.valid = 1'b0;
      return t;
    endfunction

    function bit plausible(line_track_t t, quad_fit_t f);
      longint d;
      if (!t.valid) return 1'b1;
      d = x_at_base(f) - x_at_base(t.fit);
      if (d < 0) d = -d;
      return d < longint'(jump_tol);
    endfunction

    function logic signed [OutPxW-1:0] sat_px(longint v);
      if (v < -2048) return -12'sd2048;
      if (v > 2047) return 12'sd2047;
      return v[OutPxW-1:0];
    endfunction

    // Update both tracks with one accepted frame and queue its result.
    function void note_frame(lane_frame_t f);
      result_t        res;
      longint         lx;
      longint         rx;
      longint         off;
      longint         s;
      longint         head;
      longint unsigned mag;

      if (f.over) begin
        left_track  = lose_frame(left_track);
        right_track = lose_frame(right_track);
      end else if (f.left_found && f.right_found) begin
        if (x_at_base(f.right) - x_at_base(f.left) < longint'(min_sep)) begin
          left_track  = lose_frame(left_track);
          right_track = lose_frame(right_track);
        end else begin
          left_track  = take_fit(left_track, f.left);
          right_track = take_fit(right_track, f.right);
        end
      end else begin
        if (f.left_found && plausible(left_track, f.left))
          left_track = take_fit(left_track, f.left);
        else
          left_track = lose_frame(left_track);
        if (f.right_found && plausible(right_track, f.right))
          right_track = take_fit(right_track, f.right);
        else
          right_track = lose_frame(right_track);
      end

      res          = '0;
      res.left_ok  = left_track.valid;
      res.right_ok = right_track.valid;
      res.publish  = left_track.valid && right_track.valid;
      if (res.publish) begin
        lx  = x_at_base(left_track.fit);
        rx  = x_at_base(right_track.fit);
        off = (lx + rx) / 2 - longint'(center);
        s   = slope_at_base(left_track.fit) + slope_at_base(right_track.fit);
        if (s > HeadClamp) s = HeadClamp;
        else if (s < -HeadClamp) s = -HeadClamp;
        mag = (s < 0) ? longint'(-s) : longint'(s);
        mag = (mag * 64'(HEAD_K) + (64'd1 << 46)) >> 47;
        if (mag > 64'(HEAD_MAX)) mag = 64'(HEAD_MAX);
        head = (s < 0) ? -longint'(mag) : longint'(mag);
        res.left_base_x    = sat_px(lx);
        res.right_base_x   = sat_px(rx);
        res.offset_px      = sat_px(off);
        res.heading_tenths = head[HeadW-1:0];
      end
      expected_results = {expected_results, res};
    endfunction

    // Compare one accepted result item with the oldest prediction.
    function void check_result(logic [OutDataW-1:0] data);
      result_t got;
      result_t want;
      got.publish        = data[0];
      got.left_ok        = data[1];
      got.right_ok       = data[2];
      got.left_base_x    = data[14:3];
      got.right_base_x   = data[26:15];
      got.offset_px      = data[38:27];
      got.heading_tenths = data[53:39];
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("%0t: result item with no frame outstanding: data %h", $realtime, data);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("%0t: result mismatch (publish left_ok right_ok lx rx offset heading)",
                   $realtime);
          $display("  expected %0d %0d %0d %0d %0d %0d %0d", want.publish, want.left_ok,
                   want.right_ok, want.left_base_x, want.right_base_x, want.offset_px,
                   want.heading_tenths);
          $display("  actual   %0d %0d %0d %0d %0d %0d %0d", got.publish, got.left_ok,
                   got.right_ok, got.left_base_x, got.right_base_x, got.offset_px,
                   got.heading_tenths);
        end
      end
    endfunction
  endclass

endpackage

### tb/lane_fit_tracker_unit_tb.sv
// Bench top for lane_fit_tracker_unit: directed frames, then randomized frame streams
// under several register settings. Depends on lft_pkg and lane_fit_tracker_tb_pkg.
module lane_fit_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lft_pkg::*;
  import lane_fit_tracker_tb_pkg::*;

  localparam int          ClkPeriod     = 20;
  localparam int          ResetCycles   = 4;
  localparam int unsigned IdlePercent   = 33;
  localparam int          SettleCycles  = 30;
  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned RandomPhases  = 6;
  localparam int unsigned PhaseItems    = 300;
  localparam longint      PxBound       = 1900;
  localparam logic signed [CoefW-1:0] CoefMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoefW-1:0] CoefMin = 32'sh8000_0000;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = '0;
  logic [CfgW-1:0]     cfg_wdata_i   = '0;

  lane_fit_scoreboard  board;
  bit                  steady = 1'b0;
  int unsigned         quiet_cycles = 0;

  lane_fit_tracker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Result side stalls at random, except during the steady stretch.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // Check every accepted result item.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // Count cycles in which nothing moves on any port.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("lane_fit_tracker_unit_tb: FAIL");
    $finish;
  end

  // Uniform value in [-m, m].
  function automatic longint rand_in(longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  function automatic longint clamp_px(longint v);
    if (v > PxBound) return PxBound;
    if (v < -PxBound) return -PxBound;
    return v;
  endfunction

  function automatic quad_fit_t noise_fit();
    quad_fit_t f;
    f.a = $urandom();
    f.b = $urandom();
    f.c = $urandom();
    return f;
  endfunction

  // A gently curved fit whose x at the current base row lands on px.
  function automatic quad_fit_t fit_at(longint px);
    quad_fit_t f;
    longint    y;
    longint    q;
    y   = longint'(board.base_row);
    f.a = CoefW'(rand_in(longint'(1) << 15));
    f.b = CoefW'(rand_in(longint'(1) << 17));
    q   = (clamp_px(px) <<< 30) - longint'(f.a) * y * y - longint'(f.b) * 64 * y;
    q   = (q >>> 10) + longint'($urandom_range(0, 1 << 19));
    f.c = q[CoefW-1:0];
    return f;
  endfunction

  function automatic lane_frame_t frame_of(logic over, logic lf, quad_fit_t l,
                                           logic rf, quad_fit_t r);
    lane_frame_t f;
    f.over        = over;
    f.left_found  = lf;
    f.left        = l;
    f.right_found = rf;
    f.right       = r;
    return f;
  endfunction

  // Hold a frame on the input until the block takes it; valid stays high after.
  task automatic send_frame(lane_frame_t f);
    s_axis_tdata  <= pack_frame(f);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_frame(f);
  endtask

  // Random gap before the next frame, now and then a long one.
  task automatic pause_sender();
    int unsigned gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(0, 99) < IdlePercent) gap++;
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(1, 30);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable after the last one.
  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    board.write_reg(idx, value);
  endtask

  task automatic apply_config(logic [CfgW-1:0] alpha, logic [CfgW-1:0] max_lost,
                              logic [CfgW-1:0] min_sep, logic [CfgW-1:0] jump_tol,
                              logic [CfgW-1:0] base_row, logic [CfgW-1:0] center);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_MAX_LOST, max_lost);
    write_reg(CFG_MIN_SEPARATION, min_sep);
    write_reg(CFG_JUMP_TOLERANCE, jump_tol);
    write_reg(CFG_BASE_ROW, base_row);
    write_reg(CFG_IMAGE_CENTER, center);
    cfg_we_i <= 1'b0;
  endtask

  // Register value: an extreme, fully random bits, or a typical working value.
  function automatic logic [CfgW-1:0] pick_reg(int unsigned lo, int unsigned hi,
                                               int unsigned typ_lo, int unsigned typ_hi);
    case ($urandom_range(0, 9))
      0:       return CfgW'(lo);
      1:       return CfgW'(hi);
      2:       return CfgW'($urandom_range(0, 1023));
      default: return CfgW'($urandom_range(typ_lo, typ_hi));
    endcase
  endfunction

  // Fixed frames: every decision path, field extremes and register extremes.
  task automatic run_directed();
    quad_fit_t zero_fit;
    quad_fit_t top_fit;
    quad_fit_t bottom_fit;
    zero_fit   = '0;
    top_fit    = '{CoefMax, CoefMax, CoefMax};
    bottom_fit = '{CoefMin, CoefMin, CoefMin};

    // Reset settings: loading, blending, rejections and lost frames.
    send_frame(frame_of(1'b0, 1'b0, zero_fit, 1'b0, zero_fit));
    send_frame(frame_of(1'b0, 1'b1, fit_at(200), 1'b0, zero_fit));
    send_frame(frame_of(1'b0, 1'b0, zero_fit, 1'b1, fit_at(450)));
    send_frame(frame_of(1'b0, 1'b1, fit_at(205), 1'b1, fit_at(455)));
    send_frame(frame_of(1'b0, 1'b1, fit_at(300), 1'b1, fit_at(310)));
    send_frame(frame_of(1'b1, 1'b1, fit_at(200), 1'b1, fit_at(450)));
    send_frame(frame_of(1'b0, 1'b1, fit_at(230), 1'b0, zero_fit));
    send_frame(frame_of(1'b0, 1'b1, fit_at(500), 1'b0, zero_fit));
    send_frame(frame_of(1'b0, 1'b0, zero_fit, 1'b1, fit_at(100)));
    send_frame(frame_of(1'b0, 1'b1, fit_at(450), 1'b1, fit_at(200)));

    // Full weight on new fits, no lost frames tolerated, far base row.
    drain();
    apply_config(10'd256, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023);
    send_frame(frame_of(1'b1, 1'b1, top_fit, 1'b1, top_fit));
    send_frame(frame_of(1'b0, 1'b1, bottom_fit, 1'b1, top_fit));
    send_frame(frame_of(1'b0, 1'b1, top_fit, 1'b1, top_fit));
    send_frame(frame_of(1'b0, 1'b1, bottom_fit, 1'b1, bottom_fit));
    send_frame(frame_of(1'b0, 1'b1, zero_fit, 1'b1, zero_fit));
    send_frame(frame_of(1'b1, 1'b0, zero_fit, 1'b0, zero_fit));

    // No weight on new fits, zero jump tolerance, top image row.
    drain();
    apply_config(10'd0, 10'd63, 10'd1023, 10'd0, 10'd0, 10'd0);
    send_frame(frame_of(1'b0, 1'b1, fit_at(-600), 1'b1, fit_at(600)));
    send_frame(frame_of(1'b0, 1'b1, fit_at(-600), 1'b0, zero_fit));
    send_frame(frame_of(1'b0, 1'b1, fit_at(-500), 1'b1, fit_at(700)));
  endtask

  // One random frame around the nominal lane at left_px with the given width.
  function automatic lane_frame_t random_frame(longint left_px, longint width);
    lane_frame_t f;
    int unsigned pick;
    longint      jit;
    longint      jump;
    longint      lp;
    longint      rp;
    jit  = longint'(board.jump_tol) / 2 + 2;
    jump = longint'(board.jump_tol) + longint'($urandom_range(0, 300));
    lp   = left_px + rand_in(jit);
    rp   = left_px + width + rand_in(jit);
    pick = $urandom_range(0, 99);
    f    = frame_of(1'b0, 1'b1, fit_at(lp), 1'b1, fit_at(rp));
    if (pick < 40) begin
      // both lines seen
    end else if (pick < 52) begin
      f.right_found = 1'b0;
      f.right       = noise_fit();
    end else if (pick < 64) begin
      f.left_found = 1'b0;
      f.left       = noise_fit();
    end else if (pick < 70) begin
      f.left_found  = 1'b0;
      f.right_found = 1'b0;
    end else if (pick < 76) begin
      f.over = 1'b1;
      f.left_found  = 1'($urandom_range(0, 1));
      f.right_found = 1'($urandom_range(0, 1));
    end else if (pick < 84) begin
      // Lone fit far off the track.
      if ($urandom_range(0, 1)) begin
        f.right_found = 1'b0;
        f.left        = fit_at(left_px + ($urandom_range(0, 1) ? jump : -jump));
      end else begin
        f.left_found = 1'b0;
        f.right      = fit_at(left_px + width + ($urandom_range(0, 1) ? jump : -jump));
      end
    end else if (pick < 90) begin
      // Lines too close or crossed.
      rp      = lp + longint'($urandom_range(0, board.min_sep)) - 20;
      f.right = fit_at(rp);
    end else if (pick < 95) begin
      f.over        = 1'($urandom_range(0, 1));
      f.left_found  = 1'($urandom_range(0, 1));
      f.right_found = 1'($urandom_range(0, 1));
      f.left        = noise_fit();
      f.right       = noise_fit();
    end else begin
      // Lone fit shifted from the track right at the jump tolerance.
      jump = longint'(board.jump_tol) - longint'($urandom_range(0, 1));
      jump = ($urandom_range(0, 1) ? jump : -jump) <<< 20;
      if ($urandom_range(0, 1)) begin
        f.right_found = 1'b0;
        f.left        = board.left_track.fit;
        f.left.c      = f.left.c + jump[CoefW-1:0];
      end else begin
        f.left_found = 1'b0;
        f.right      = board.right_track.fit;
        f.right.c    = f.right.c + jump[CoefW-1:0];
      end
    end
    return f;
  endfunction

  // A stream of random frames around a slowly drifting lane.
  task automatic run_phase(int unsigned count, bit with_pause, bit with_steady);
    longint width;
    longint left_px;
    width   = longint'(board.min_sep) + longint'($urandom_range(10, 250));
    left_px = longint'(board.center) - width / 2 + rand_in(40);
    for (int unsigned n = 0; n < count; n++) begin
      if (with_steady) steady = (n >= count / 4) && (n < 3 * count / 4);
      if (with_pause && n == count / 2) begin
        s_axis_tvalid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge clk_i);
      end
      left_px = clamp_px(left_px + rand_in(2));
      if (left_px + width > PxBound) left_px = PxBound - width;
      pause_sender();
      send_frame(random_frame(left_px, width));
    end
    steady = 1'b0;
  endtask

  initial begin
    board = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();

    for (int unsigned p = 0; p < RandomPhases; p++) begin
      drain();
      apply_config(pick_reg(0, 256, 16, 240), pick_reg(0, 63, 0, 15),
                   pick_reg(0, 1023, 40, 300), pick_reg(0, 1023, 10, 120),
                   pick_reg(0, 1023, 200, 1023), pick_reg(0, 1023, 100, 700));
      run_phase(PhaseItems, p == 1, p == 2);
    end

    drain();
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("lane_fit_tracker_unit_tb: PASS");
    end else begin
      $display("lane_fit_tracker_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/lft_pkg.sv
src/lft_lane.sv
src/lft_merge.sv
src/lane_fit_tracker_unit.sv
src/lft_checker.sv
tb/lane_fit_tracker_tb_pkg.sv
tb/lane_fit_tracker_unit_tb.sv
